[rtl/core/tga_truecolor_to_rgba_core_macros.svh]
// ----------------------------------------------------------------------------
// tga assertion macros
// shared concurrent assertion forms for the tga truecolor decoder
// ----------------------------------------------------------------------------
`ifndef TGA_TRUECOLOR_TO_RGBA_CORE_MACROS_SVH
`define TGA_TRUECOLOR_TO_RGBA_CORE_MACROS_SVH

// implication or plain property, checked on every clock outside reset
`define TGA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be seen outside reset
`define TGA_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[rtl/core/tga_pkg.sv]
// ----------------------------------------------------------------------------
// tga package
// shared types, status codes and header constants of the tga decoder
// ----------------------------------------------------------------------------
package tga_pkg;

   localparam int unsigned MAX_PIXELS = 1048576;
   localparam int unsigned QDEPTH     = 4;
   localparam int unsigned QPTR_W     = $clog2(QDEPTH);
   localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);
   localparam int unsigned IDX_W      = 20;

   // header layout
   localparam logic [4:0] HDR_LEN      = 5'd18;
   localparam logic [4:0] HDR_TYPE     = 5'd2;
   localparam logic [4:0] HDR_W_LO     = 5'd12;
   localparam logic [4:0] HDR_W_HI     = 5'd13;
   localparam logic [4:0] HDR_H_LO     = 5'd14;
   localparam logic [4:0] HDR_H_HI     = 5'd15;
   localparam logic [4:0] HDR_DEPTH    = 5'd16;
   localparam logic [4:0] HDR_DESC     = 5'd17;
   localparam logic [7:0] IMG_TRUE     = 8'd2;
   localparam logic [7:0] DEPTH_24     = 8'd24;
   localparam logic [7:0] DEPTH_32     = 8'd32;
   localparam int unsigned DESC_TOP    = 5;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_SHORT_HDR = 3'd1;
   localparam logic [2:0] ST_BAD_TYPE  = 3'd2;
   localparam logic [2:0] ST_BAD_DIMS  = 3'd3;
   localparam logic [2:0] ST_SHORT_DAT = 3'd4;
   localparam logic [2:0] ST_TOO_LARGE = 3'd5;

   typedef struct packed {
      logic             is_status;
      logic [IDX_W-1:0] dest_index;
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
      logic [7:0]       alpha;
      logic [2:0]       status;
      logic [15:0]      width;
      logic [15:0]      height;
      logic             final_res;
   } res_type;

endpackage

[rtl/core/tga_truecolor_to_rgba_core.sv]
// ----------------------------------------------------------------------------
// tga truecolor to rgba core
// decodes an uncompressed 24/32-bit tga byte stream into rgba pixels with
// top-down destination indexes and one closing status per file
// ----------------------------------------------------------------------------
//  channel  direction  beat
//  req_     in         one file byte plus end-of-file flag
//  rsp_     out        one pixel or one final status
//
//  a byte is registered on entry, decoded once the queue has room for two results,
//  and its results land in a four-entry result queue; one byte per cycle sustained while rsp_ready stays high.
//  a byte that ends a file and completes a pixel gives two beats, pixel first.
//  the input stage moves on only while the queue has two free slots, so
//  rsp_ready low backs up into req_ready once the queue holds more than two results.
//  reset clears all control state at once; no clearing pass.
// ----------------------------------------------------------------------------
`include "tga_truecolor_to_rgba_core_macros.svh"

module tga_truecolor_to_rgba_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_is_status,
   output logic [19:0] rsp_dest_index,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_width,
   output logic [15:0] rsp_height,
   output logic        rsp_final_res
);

   logic                       in_v_ff, in_v_in;
   logic [7:0]                 in_byte_ff, in_byte_in;
   logic                       in_last_ff, in_last_in;
   logic                       advance;
   logic [tga_pkg::QCNT_W-1:0] q_level;
   logic                       pix_valid;
   tga_pkg::res_type           pix;
   logic                       st_valid;
   tga_pkg::res_type           st;
   tga_pkg::res_type           head;

   // room for a pixel and a status from the same beat
   assign advance   = in_v_ff && (q_level <= tga_pkg::QCNT_W'(tga_pkg::QDEPTH - 2));
   assign req_ready = !in_v_ff || advance;

   always_comb begin
      in_v_in    = in_v_ff;
      in_byte_in = in_byte_ff;
      in_last_in = in_last_ff;
      if (req_valid && req_ready) begin
         in_v_in    = 1'b1;
         in_byte_in = req_data_byte;
         in_last_in = req_last_byte;
      end else if (advance) begin
         in_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else begin
         in_v_ff <= in_v_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
   end

   tga_dec u_dec (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .pix_valid (pix_valid),
      .pix       (pix),
      .st_valid  (st_valid),
      .st        (st)
   );

   tga_outq u_outq (
      .clock        (clock),
      .reset        (reset),
      .push_a_valid (pix_valid),
      .push_a       (pix),
      .push_b_valid (st_valid),
      .push_b       (st),
      .pop_valid    (rsp_valid),
      .pop_ready    (rsp_ready),
      .pop_data     (head),
      .level        (q_level)
   );

   assign rsp_is_status  = head.is_status;
   assign rsp_dest_index = head.dest_index;
   assign rsp_red        = head.red;
   assign rsp_green      = head.green;
   assign rsp_blue       = head.blue;
   assign rsp_alpha      = head.alpha;
   assign rsp_status     = head.status;
   assign rsp_width      = head.width;
   assign rsp_height     = head.height;
   assign rsp_final_res  = head.final_res;

   `TGA_ASSERT_NEVER(a_queue_bound, clock, reset, q_level > tga_pkg::QCNT_W'(tga_pkg::QDEPTH), "result queue overfilled")
   `TGA_ASSERT(a_step_room, clock, reset, advance |-> q_level <= tga_pkg::QCNT_W'(tga_pkg::QDEPTH - 2), "decode step without room for two results")
   `TGA_ASSERT(a_status_shape, clock, reset, (rsp_valid && rsp_is_status) |-> (rsp_final_res && rsp_dest_index == '0 && rsp_alpha == '0), "status beat carries pixel fields")
   `TGA_ASSERT(a_pixel_shape, clock, reset, (rsp_valid && !rsp_is_status) |-> (!rsp_final_res && rsp_status == tga_pkg::ST_OK && rsp_width == '0), "pixel beat carries status fields")

endmodule

[rtl/core/tga_dec.sv]
// ----------------------------------------------------------------------------
// tga byte decoder
// header capture and verdict, pixel assembly, row flip and status build
// ----------------------------------------------------------------------------
module tga_dec (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       data_byte,
   input  logic             last_byte,
   output logic             pix_valid,
   output tga_pkg::res_type pix,
   output logic             st_valid,
   output tga_pkg::res_type st
);

   logic [4:0]                 hdr_cnt_ff, hdr_cnt_in;
   logic                       type_ok_ff, type_ok_in;
   logic [15:0]                width_ff, width_in;
   logic [15:0]                height_ff, height_in;
   logic [7:0]                 depth_ff, depth_in;
   logic                       top_down_ff, top_down_in;
   logic [2:0]                 err_ff, err_in;
   logic [1:0]                 chan_ff, chan_in;
   logic [7:0]                 hold_ff [3];
   logic [7:0]                 hold_in [3];
   logic [15:0]                col_ff, col_in;
   logic [15:0]                row_ff, row_in;
   logic [tga_pkg::IDX_W-1:0]  base_ff, base_in;
   logic [31:0]                prod_ff;

   logic       need4;
   logic [1:0] last_chan;
   logic       dims_bad;

   // area is recomputed every cycle, settled well before the descriptor byte
   always_ff @(posedge clock) begin
      prod_ff <= 32'(width_ff) * 32'(height_ff);
   end

   always_comb begin
      need4     = (depth_ff == tga_pkg::DEPTH_32);
      last_chan = need4 ? 2'd3 : 2'd2;
      dims_bad  = (width_ff == 16'd0) || (height_ff == 16'd0) ||
                  ((depth_ff != tga_pkg::DEPTH_24) && (depth_ff != tga_pkg::DEPTH_32));

      hdr_cnt_in = hdr_cnt_ff;
      type_ok_in = type_ok_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      depth_in   = depth_ff;
      err_in     = err_ff;
      chan_in    = chan_ff;
      hold_in    = hold_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      base_in    = base_ff;
      pix_valid  = 1'b0;
      pix        = '0;
      st_valid   = 1'b0;
      st         = '0;

      if (step) begin
         if (hdr_cnt_ff < tga_pkg::HDR_LEN) begin
            hdr_cnt_in = hdr_cnt_ff + 5'd1;
            case (hdr_cnt_ff)
               tga_pkg::HDR_TYPE:  type_ok_in = (data_byte == tga_pkg::IMG_TRUE);
               tga_pkg::HDR_W_LO:  width_in[7:0] = data_byte;
               tga_pkg::HDR_W_HI:  width_in[15:8] = data_byte;
               tga_pkg::HDR_H_LO:  height_in[7:0] = data_byte;
               tga_pkg::HDR_H_HI:  height_in[15:8] = data_byte;
               tga_pkg::HDR_DEPTH: depth_in = data_byte;
               tga_pkg::HDR_DESC: begin
                  if (!type_ok_ff) begin
                     err_in = tga_pkg::ST_BAD_TYPE;
                  end else if (dims_bad) begin
                     err_in = tga_pkg::ST_BAD_DIMS;
                  end else if (prod_ff > 32'(tga_pkg::MAX_PIXELS)) begin
                     err_in = tga_pkg::ST_TOO_LARGE;
                  end else begin
                     err_in = tga_pkg::ST_OK;
                  end
                  // bottom-up files start on the last output row
                  base_in = data_byte[tga_pkg::DESC_TOP] ? '0 :
                            prod_ff[tga_pkg::IDX_W-1:0] - tga_pkg::IDX_W'(width_ff);
               end
               default: ;
            endcase
         end else if ((err_ff == tga_pkg::ST_OK) && (row_ff < height_ff)) begin
            if (chan_ff != last_chan) begin
               hold_in[chan_ff] = data_byte;
               chan_in          = chan_ff + 2'd1;
            end else begin
               pix_valid      = 1'b1;
               pix.dest_index = base_ff + tga_pkg::IDX_W'(col_ff);
               pix.red        = need4 ? hold_ff[2] : data_byte;
               pix.green      = hold_ff[1];
               pix.blue       = hold_ff[0];
               pix.alpha      = need4 ? data_byte : tga_pkg::ALPHA_OPAQUE;
               chan_in        = 2'd0;
               if (({1'b0, col_ff} + 17'd1) < {1'b0, width_ff}) begin
                  col_in = col_ff + 16'd1;
               end else begin
                  col_in = 16'd0;
                  row_in = row_ff + 16'd1;
                  if (top_down_ff) begin
                     base_in = base_ff + tga_pkg::IDX_W'(width_ff);
                  end else begin
                     base_in = base_ff - tga_pkg::IDX_W'(width_ff);
                  end
               end
            end
         end

         if (last_byte) begin
            st_valid     = 1'b1;
            st.is_status = 1'b1;
            st.final_res = 1'b1;
            st.width     = width_in;
            st.height    = height_in;
            if (hdr_cnt_in < tga_pkg::HDR_LEN) begin
               st.status = tga_pkg::ST_SHORT_HDR;
            end else if (err_in != tga_pkg::ST_OK) begin
               st.status = err_in;
            end else if (row_in < height_ff) begin
               st.status = tga_pkg::ST_SHORT_DAT;
            end else begin
               st.status = tga_pkg::ST_OK;
            end
            // file ends, next beat opens a new one
            hdr_cnt_in = '0;
            type_ok_in = 1'b0;
            width_in   = '0;
            height_in  = '0;
            depth_in   = '0;
            err_in     = tga_pkg::ST_OK;
            chan_in    = '0;
            col_in     = '0;
            row_in     = '0;
            base_in    = '0;
         end
      end
   end

   always_comb begin
      top_down_in = top_down_ff;
      if (step) begin
         if (hdr_cnt_ff == tga_pkg::HDR_DESC) begin
            top_down_in = data_byte[tga_pkg::DESC_TOP];
         end
         if (last_byte) begin
            top_down_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_cnt_ff  <= '0;
         type_ok_ff  <= 1'b0;
         width_ff    <= '0;
         height_ff   <= '0;
         depth_ff    <= '0;
         top_down_ff <= 1'b0;
         err_ff      <= tga_pkg::ST_OK;
         chan_ff     <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         base_ff     <= '0;
      end else begin
         hdr_cnt_ff  <= hdr_cnt_in;
         type_ok_ff  <= type_ok_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         depth_ff    <= depth_in;
         top_down_ff <= top_down_in;
         err_ff      <= err_in;
         chan_ff     <= chan_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         base_ff     <= base_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

endmodule

[rtl/core/tga_outq.sv]
// ----------------------------------------------------------------------------
// tga result queue
// small register queue taking up to two results per cycle, one out per cycle while pop_ready is high
// ----------------------------------------------------------------------------
module tga_outq (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_a_valid,
   input  tga_pkg::res_type           push_a,
   input  logic                       push_b_valid,
   input  tga_pkg::res_type           push_b,
   output logic                       pop_valid,
   input  logic                       pop_ready,
   output tga_pkg::res_type           pop_data,
   output logic [tga_pkg::QCNT_W-1:0] level
);

   tga_pkg::res_type            mem_ff [tga_pkg::QDEPTH];
   logic [tga_pkg::QPTR_W-1:0]  wr_ff, wr_in;
   logic [tga_pkg::QPTR_W-1:0]  rd_ff, rd_in;
   logic [tga_pkg::QCNT_W-1:0]  cnt_ff, cnt_in;
   logic                        pop;
   logic                        both;
   logic                        any;
   tga_pkg::res_type            first;

   always_comb begin
      pop       = pop_valid && pop_ready;
      both      = push_a_valid && push_b_valid;
      any       = push_a_valid || push_b_valid;
      first     = push_a_valid ? push_a : push_b;
      wr_in     = wr_ff + (both ? tga_pkg::QPTR_W'(2) : tga_pkg::QPTR_W'(any));
      rd_in     = rd_ff + tga_pkg::QPTR_W'(pop);
      cnt_in    = cnt_ff + (both ? tga_pkg::QCNT_W'(2) : tga_pkg::QCNT_W'(any))
                  - tga_pkg::QCNT_W'(pop);
      pop_valid = (cnt_ff != '0);
      pop_data  = mem_ff[rd_ff];
      level     = cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (any) begin
         mem_ff[wr_ff] <= first;
      end
      if (both) begin
         mem_ff[wr_ff + tga_pkg::QPTR_W'(1)] <= push_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

[sim/tga_truecolor_to_rgba_core_test.sv]
// ----------------------------------------------------------------------------
// tga truecolor to rgba core testbench
// feeds whole tga files a byte per beat, well-formed ones with random content
// and sizes plus broken headers, short data, surplus bytes and noise; every
// pixel and status beat is checked against a byte-level decoder kept here,
// or, for the typed directed bytes, against the beats listed with them
module tga_truecolor_to_rgba_core_test;

   localparam int unsigned RANDOM_BYTES = 1100;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned HOLD_CYCLES  = 150;
   localparam int unsigned DRAIN_CYCLES = 16;
   localparam int unsigned MAX_SHOWN    = 40;

   typedef struct packed {
      logic [7:0]       data;
      logic             last;
      logic             typed;
      logic [1:0]       ntyped;
      tga_pkg::res_type e0;
      tga_pkg::res_type e1;
   } stim_row_type;

   logic        clock;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready     = 1'b0;
   logic        rsp_is_status;
   logic [19:0] rsp_dest_index;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic [7:0]  rsp_alpha;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_width;
   logic [15:0] rsp_height;
   logic        rsp_final_res;

   tga_truecolor_to_rgba_core DUT (.*);

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // decoder state
   logic [7:0]                hdr [18];
   int unsigned               byte_cnt;
   logic [7:0]                chan [3];
   int unsigned               chan_cnt;
   int unsigned               col;
   int unsigned               row;
   logic [tga_pkg::IDX_W-1:0] row_base;
   logic [2:0]                hdr_verdict;
   tga_pkg::res_type          step_out [2];
   int unsigned               step_n;

   tga_pkg::res_type decoded_beats [$];
   stim_row_type     directed_rows [$];
   logic [7:0]       file_bytes [$];
   stim_row_type     cur_row;
   tga_pkg::res_type seen;
   int unsigned fail_cnt, beat_cnt, bytes_taken, input_stalls, cycle_cnt;
   int unsigned pixels_out, files_sent, holds_done, burst_left;
   int unsigned status_seen [8];

   function automatic tga_pkg::res_type mk_beat(input logic is_st,
                                                input logic [tga_pkg::IDX_W-1:0] idx,
                                                input logic [7:0] r, g, b, a,
                                                input logic [2:0] st,
                                                input logic [15:0] w, h);
      tga_pkg::res_type x;
      x.is_status  = is_st;
      x.dest_index = idx;
      x.red        = r;
      x.green      = g;
      x.blue       = b;
      x.alpha      = a;
      x.status     = st;
      x.width      = w;
      x.height     = h;
      x.final_res  = is_st;
      return x;
   endfunction

   function automatic void clear_decoder();
      foreach (hdr[i]) hdr[i] = 8'h00;
      foreach (chan[i]) chan[i] = 8'h00;
      byte_cnt    = 0;
      chan_cnt    = 0;
      col         = 0;
      row         = 0;
      row_base    = '0;
      hdr_verdict = tga_pkg::ST_OK;
   endfunction

   // results of one file byte land in step_out[0..step_n-1]
   function automatic void decode_byte(input logic [7:0] b, input logic last);
      int unsigned w, h, need;
      logic [7:0]  alpha;
      logic [2:0]  st;
      step_n = 0;
      w = {hdr[tga_pkg::HDR_W_HI], hdr[tga_pkg::HDR_W_LO]};
      h = {hdr[tga_pkg::HDR_H_HI], hdr[tga_pkg::HDR_H_LO]};
      if (byte_cnt < tga_pkg::HDR_LEN) begin
         hdr[byte_cnt] = b;
         if (byte_cnt == tga_pkg::HDR_LEN - 1) begin
            w = {hdr[tga_pkg::HDR_W_HI], hdr[tga_pkg::HDR_W_LO]};
            h = {hdr[tga_pkg::HDR_H_HI], hdr[tga_pkg::HDR_H_LO]};
            if (hdr[tga_pkg::HDR_TYPE] != tga_pkg::IMG_TRUE)
               hdr_verdict = tga_pkg::ST_BAD_TYPE;
            else if (w == 0 || h == 0 ||
                     (hdr[tga_pkg::HDR_DEPTH] != tga_pkg::DEPTH_24 &&
                      hdr[tga_pkg::HDR_DEPTH] != tga_pkg::DEPTH_32))
               hdr_verdict = tga_pkg::ST_BAD_DIMS;
            else if (longint'(w) * longint'(h) > longint'(tga_pkg::MAX_PIXELS))
               hdr_verdict = tga_pkg::ST_TOO_LARGE;
            else
               hdr_verdict = tga_pkg::ST_OK;
            // bottom-up files start on the last output row
            if (hdr_verdict == tga_pkg::ST_OK)
               row_base = hdr[tga_pkg::HDR_DESC][tga_pkg::DESC_TOP] ? '0 :
                          tga_pkg::IDX_W'((h - 1) * w);
         end
      end else if (hdr_verdict == tga_pkg::ST_OK && row < h) begin
         need = (hdr[tga_pkg::HDR_DEPTH] == tga_pkg::DEPTH_32) ? 4 : 3;
         if (chan_cnt + 1 < need) begin
            chan[chan_cnt] = b;
            chan_cnt++;
         end else begin
            alpha = tga_pkg::ALPHA_OPAQUE;
            if (need == 4) alpha = b;
            else chan[2] = b;
            step_out[step_n] = mk_beat(1'b0, tga_pkg::IDX_W'(row_base + col), chan[2],
                                       chan[1], chan[0], alpha, tga_pkg::ST_OK,
                                       16'd0, 16'd0);
            step_n++;
            chan_cnt = 0;
            if (col + 1 < w) begin
               col++;
            end else begin
               col = 0;
               row++;
               if (hdr[tga_pkg::HDR_DESC][tga_pkg::DESC_TOP])
                  row_base = tga_pkg::IDX_W'(row_base + w);
               else
                  row_base = tga_pkg::IDX_W'(row_base - w);
            end
         end
      end
      if (byte_cnt != 32'hFFFF_FFFF) byte_cnt++;
      if (last) begin
         if (byte_cnt < tga_pkg::HDR_LEN) st = tga_pkg::ST_SHORT_HDR;
         else if (hdr_verdict != tga_pkg::ST_OK) st = hdr_verdict;
         else if (row < h) st = tga_pkg::ST_SHORT_DAT;
         else st = tga_pkg::ST_OK;
         step_out[step_n] = mk_beat(1'b1, '0, 8'h00, 8'h00, 8'h00, 8'h00, st,
                                    {hdr[tga_pkg::HDR_W_HI], hdr[tga_pkg::HDR_W_LO]},
                                    {hdr[tga_pkg::HDR_H_HI], hdr[tga_pkg::HDR_H_LO]});
         step_n++;
         clear_decoder();
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                  input logic [63:0] want_v);
      fail_cnt++;
      if (fail_cnt <= MAX_SHOWN)
         $display("mismatch at beat %0d, %s: got %0h, expected %0h",
                  beat_cnt, what, got_v, want_v);
   endtask

   task automatic compare_beat(input tga_pkg::res_type g, input tga_pkg::res_type w);
      if (g.is_status !== w.is_status)   report_mismatch("is_status", g.is_status, w.is_status);
      if (g.dest_index !== w.dest_index) report_mismatch("dest_index", g.dest_index, w.dest_index);
      if (g.red !== w.red)               report_mismatch("red", g.red, w.red);
      if (g.green !== w.green)           report_mismatch("green", g.green, w.green);
      if (g.blue !== w.blue)             report_mismatch("blue", g.blue, w.blue);
      if (g.alpha !== w.alpha)           report_mismatch("alpha", g.alpha, w.alpha);
      if (g.status !== w.status)         report_mismatch("status", g.status, w.status);
      if (g.width !== w.width)           report_mismatch("width", g.width, w.width);
      if (g.height !== w.height)         report_mismatch("height", g.height, w.height);
      if (g.final_res !== w.final_res)   report_mismatch("final_res", g.final_res, w.final_res);
   endtask

   // output beats are checked before the byte taken at the same edge is decoded
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_is_status, rsp_dest_index, rsp_red, rsp_green, rsp_blue, rsp_alpha,
                    rsp_status, rsp_width, rsp_height, rsp_final_res};
            beat_cnt++;
            if (seen.is_status) status_seen[seen.status]++;
            else pixels_out++;
            if (decoded_beats.size() == 0)
               report_mismatch("beat with nothing pending", seen.is_status, 1'b0);
            else
               compare_beat(seen, decoded_beats.pop_front());
         end
         if (req_valid && req_ready) begin
            decode_byte(req_data_byte, req_last_byte);
            bytes_taken++;
            if (!cur_row.typed) begin
               for (int i = 0; i < step_n; i++) decoded_beats.push_back(step_out[i]);
            end else begin
               if (cur_row.ntyped > 0) decoded_beats.push_back(cur_row.e0);
               if (cur_row.ntyped > 1) decoded_beats.push_back(cur_row.e1);
            end
         end else if (req_valid) begin
            input_stalls++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats still pending",
                  cycle_cnt, decoded_beats.size());
         $display("FAIL tga_truecolor_to_rgba_core");
         $finish;
      end
   end

   // receiver: segments of differing stall density, plus long hold-offs
   initial begin
      int unsigned seg_len, mode;
      forever begin
         seg_len = $urandom_range(10, 60);
         mode    = $urandom_range(0, 3);
         repeat (seg_len) begin
            @(negedge clock);
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) == 1);
               2: rsp_ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
         if (holds_done < 2 && bytes_taken > 200 + 500 * holds_done) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            holds_done++;
         end
      end
   end

   // sender works in bursts; the beat stays up until taken
   task automatic send_byte(input stim_row_type r);
      int unsigned gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      cur_row = r;
      req_valid     <= 1'b1;
      req_data_byte <= r.data;
      req_last_byte <= r.last;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic add_row(input logic [7:0] data, input logic last, input logic typed,
                          input logic [1:0] ntyped, input tga_pkg::res_type e0,
                          input tga_pkg::res_type e1);
      stim_row_type r;
      r.data   = data;
      r.last   = last;
      r.typed  = typed;
      r.ntyped = ntyped;
      r.e0     = e0;
      r.e1     = e1;
      directed_rows.push_back(r);
   endtask

   task automatic make_random_file();
      int unsigned kind, w, h, body, pix_bytes;
      logic [7:0]  ftype, depth;
      file_bytes.delete();
      kind  = $urandom_range(0, 99);
      ftype = tga_pkg::IMG_TRUE;
      depth = ($urandom_range(0, 1) == 1) ? tga_pkg::DEPTH_32 : tga_pkg::DEPTH_24;
      w     = $urandom_range(1, 4);
      h     = $urandom_range(1, 3);
      if ($urandom_range(0, 7) == 0) w = $urandom_range(5, 24);
      pix_bytes = w * h * ((depth == tga_pkg::DEPTH_32) ? 4 : 3);
      body      = pix_bytes;
      if (kind < 8 || kind >= 92) begin
         // truncated header or plain noise
         repeat ((kind < 8) ? $urandom_range(1, 17) : $urandom_range(1, 40))
            file_bytes.push_back(8'($urandom));
         return;
      end
      if (kind < 60) begin
         case ($urandom_range(0, 5))
            0: body = pix_bytes - $urandom_range(1, pix_bytes);
            1: body = pix_bytes + $urandom_range(1, 6);
            default: ;
         endcase
      end else if (kind < 68) begin
         do ftype = 8'($urandom); while (ftype == tga_pkg::IMG_TRUE);
         body = $urandom_range(0, 6);
      end else if (kind < 76) begin
         case ($urandom_range(0, 3))
            0: w = 0;
            1: h = 0;
            2: begin
               w = 0;
               h = 0;
            end
            default: begin
               do depth = 8'($urandom);
               while (depth == tga_pkg::DEPTH_24 || depth == tga_pkg::DEPTH_32);
            end
         endcase
         body = $urandom_range(0, 6);
      end else if (kind < 84) begin
         case ($urandom_range(0, 3))
            0: begin
               w = 65535;
               h = 65535;
            end
            1: begin
               w = 1024;
               h = 1025;
            end
            2: begin
               w = 65535;
               h = 17;
            end
            default: begin
               w = $urandom_range(1025, 65535);
               h = $urandom_range(1025, 65535);
            end
         endcase
         body = $urandom_range(0, 6);
      end else begin
         // legal but huge image, only its first pixels are sent
         case ($urandom_range(0, 2))
            0: begin
               w = 1024;
               h = 1024;
            end
            1: begin
               w = 65535;
               h = 16;
            end
            default: begin
               w = $urandom_range(256, 2048);
               h = $urandom_range(256, 512);
            end
         endcase
         body = $urandom_range(1, 30);
      end
      repeat (tga_pkg::HDR_LEN) file_bytes.push_back(8'($urandom));
      file_bytes[tga_pkg::HDR_TYPE]  = ftype;
      file_bytes[tga_pkg::HDR_W_LO]  = w[7:0];
      file_bytes[tga_pkg::HDR_W_HI]  = w[15:8];
      file_bytes[tga_pkg::HDR_H_LO]  = h[7:0];
      file_bytes[tga_pkg::HDR_H_HI]  = h[15:8];
      file_bytes[tga_pkg::HDR_DEPTH] = depth;
      repeat (body) file_bytes.push_back(8'($urandom));
   endtask

   initial begin
      tga_pkg::res_type none, st_short, px;
      stim_row_type r;
      clear_decoder();
      none     = '0;
      st_short = mk_beat(1'b1, '0, 8'h00, 8'h00, 8'h00, 8'h00, tga_pkg::ST_SHORT_HDR,
                         16'd0, 16'd0);
      px       = mk_beat(1'b0, '0, 8'hFF, 8'h80, 8'h00, tga_pkg::ALPHA_OPAQUE,
                         tga_pkg::ST_OK, 16'd0, 16'd0);

      // one-byte files, then a 1x1 top-down 24-bit image whose last byte
      // completes the pixel and closes the file
      add_row(8'h00, 1'b1, 1'b1, 2'd1, st_short, none);
      add_row(8'hFF, 1'b1, 1'b1, 2'd1, st_short, none);
      add_row(8'h00, 1'b0, 1'b0, 2'd0, none, none);          // id length
      add_row(8'h00, 1'b0, 1'b0, 2'd0, none, none);          // color map type
      add_row(tga_pkg::IMG_TRUE, 1'b0, 1'b0, 2'd0, none, none);
      repeat (9) add_row(8'h00, 1'b0, 1'b0, 2'd0, none, none);
      add_row(8'h01, 1'b0, 1'b0, 2'd0, none, none);          // width
      add_row(8'h00, 1'b0, 1'b0, 2'd0, none, none);
      add_row(8'h01, 1'b0, 1'b0, 2'd0, none, none);          // height
      add_row(8'h00, 1'b0, 1'b0, 2'd0, none, none);
      add_row(tga_pkg::DEPTH_24, 1'b0, 1'b0, 2'd0, none, none);
      add_row(8'h20, 1'b0, 1'b0, 2'd0, none, none);          // top-down
      add_row(8'h00, 1'b0, 1'b0, 2'd0, none, none);          // blue
      add_row(8'h80, 1'b0, 1'b0, 2'd0, none, none);          // green
      add_row(8'hFF, 1'b1, 1'b1, 2'd2, px,
              mk_beat(1'b1, '0, 8'h00, 8'h00, 8'h00, 8'h00, tga_pkg::ST_OK,
                      16'd1, 16'd1));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_byte(directed_rows[i]);
      files_sent = 3;

      while (bytes_taken < RANDOM_BYTES + directed_rows.size()) begin
         make_random_file();
         foreach (file_bytes[i]) begin
            r      = '0;
            r.data = file_bytes[i];
            r.last = (i == file_bytes.size() - 1);
            send_byte(r);
         end
         files_sent++;
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (decoded_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run: %0d files, %0d bytes in, %0d pixel beats, input held off %0d cycles",
               files_sent, bytes_taken, pixels_out, input_stalls);
      $display("status beats ok %0d, short hdr %0d, type %0d, dims %0d, short data %0d, big %0d",
               status_seen[tga_pkg::ST_OK], status_seen[tga_pkg::ST_SHORT_HDR],
               status_seen[tga_pkg::ST_BAD_TYPE], status_seen[tga_pkg::ST_BAD_DIMS],
               status_seen[tga_pkg::ST_SHORT_DAT], status_seen[tga_pkg::ST_TOO_LARGE]);
      if (fail_cnt == 0)
         $display("PASS tga_truecolor_to_rgba_core");
      else
         $display("FAIL tga_truecolor_to_rgba_core");
      $finish;
   end

endmodule
